>>> rtl/pae_pkg.sv
// Shared types and constants for the polyphonic envelope generator.
package pae_pkg;

    // Input modes
    localparam logic [1:0] MODE_TICK     = 2'd0;
    localparam logic [1:0] MODE_NOTE_ON  = 2'd1;
    localparam logic [1:0] MODE_NOTE_OFF = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_ATTACK_TARGET = 3'd0;
    localparam logic [2:0] CFG_ATTACK_RATE   = 3'd1;
    localparam logic [2:0] CFG_DECAY_TARGET  = 3'd2;
    localparam logic [2:0] CFG_DECAY_RATE    = 3'd3;
    localparam logic [2:0] CFG_SUSTAIN_RATE  = 3'd4;
    localparam logic [2:0] CFG_RELEASE_RATE  = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Largest number of voices reported on a tick
    localparam int MAX_REPORT = 8;

    typedef enum logic [2:0] {
        PH_OFF     = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } t_phase;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] voice_sel;
    } t_in_beat;

    typedef struct packed {
        logic [2:0] voice_index;
        logic [7:0] level;
        logic [2:0] phase_code;
        logic       granted;
        logic       last;
    } t_out_beat;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic cnt_inc;
        logic do_tick;
        logic do_alloc;
        logic do_nogrant;
        logic do_off;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic busy_cur;
        logic cnt_last;
        logic cnt_report;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/pae_ctrl.sv
// Sequencer for the envelope generator: walks the voices for each input beat.
module pae_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_mode,
    input  pae_pkg::t_stat i_stat,
    output pae_pkg::t_cmd  o_cmd
);
    import pae_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_ALLOC,
        ST_OFF
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_stall = (r_state != ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_mode)
                        MODE_TICK:     n_state = ST_TICK;
                        MODE_NOTE_ON:  n_state = ST_ALLOC;
                        MODE_NOTE_OFF: n_state = ST_OFF;
                        default:       n_state = ST_IDLE;
                    endcase
                end
            end
            ST_TICK: begin
                // Voices beyond the reported ones step without a result
                if (!i_stat.cnt_report || i_stat.out_free) begin
                    o_cmd.do_tick = 1'b1;
                    if (i_stat.cnt_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                    end
                end
            end
            ST_ALLOC: begin
                if (!i_stat.busy_cur) begin
                    if (i_stat.out_free) begin
                        o_cmd.do_alloc = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end else if (i_stat.cnt_last) begin
                    if (i_stat.out_free) begin
                        o_cmd.do_nogrant = 1'b1;
                        n_state          = ST_IDLE;
                    end
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            ST_OFF: begin
                if (i_stat.out_free) begin
                    o_cmd.do_off = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/pae_datapath.sv
// Voice state, configuration registers, envelope step logic and output register.
module pae_datapath #(
    parameter int NUM_VOICES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [pae_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pae_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  pae_pkg::t_in_beat             i_in_data,
    input  pae_pkg::t_cmd                 i_cmd,
    output pae_pkg::t_stat                o_stat,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pae_pkg::t_out_beat            o_out_data
);
    import pae_pkg::*;

    localparam int VW      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int NREPORT = (NUM_VOICES < MAX_REPORT) ? NUM_VOICES : MAX_REPORT;

    // Configuration
    logic [7:0]  r_attack_target;
    logic [15:0] r_attack_rate;
    logic [7:0]  r_decay_target;
    logic [15:0] r_decay_rate;
    logic [15:0] r_sustain_rate;
    logic [15:0] r_release_rate;

    // Per-voice state
    t_phase                r_phase [NUM_VOICES];
    logic [7:0]            r_delay [NUM_VOICES];
    logic [7:0]            r_level [NUM_VOICES];
    logic [NUM_VOICES-1:0] r_busy;

    // Current beat
    logic [VW-1:0] r_cnt;
    logic [2:0]    r_sel;
    logic          r_sel_ok;

    logic      r_out_valid;
    t_out_beat r_out;

    // Current voice read
    t_phase     cur_ph;
    logic [7:0] cur_lvl;
    logic [7:0] cur_dc;
    logic       sel_in_range;
    logic       out_free;

    // Step results
    logic [15:0] rate;
    logic [7:0]  step;
    logic [7:0]  dc_inc;
    logic        fire;
    logic [8:0]  sum;
    t_phase      nx_ph;
    logic [7:0]  nx_lvl;
    logic [7:0]  nx_dc;
    logic        nx_free;
    t_phase      off_ph;
    logic        off_chg;
    logic        report_last;

    assign cur_ph       = r_phase[r_cnt];
    assign cur_lvl      = r_level[r_cnt];
    assign cur_dc       = r_delay[r_cnt];
    assign sel_in_range = (32'(i_in_data.voice_sel) < NUM_VOICES);
    assign out_free     = !r_out_valid || !i_out_stall;
    assign report_last  = (32'(r_cnt) == NREPORT - 1);

    assign o_stat.busy_cur   = r_busy[r_cnt];
    assign o_stat.cnt_last   = (r_cnt == VW'(NUM_VOICES - 1));
    assign o_stat.cnt_report = (32'(r_cnt) < NREPORT);
    assign o_stat.out_free   = out_free;

    // One envelope step of the current voice
    always_comb begin
        case (cur_ph)
            PH_ATTACK:  rate = r_attack_rate;
            PH_DECAY:   rate = r_decay_rate;
            PH_SUSTAIN: rate = r_sustain_rate;
            PH_RELEASE: rate = r_release_rate;
            default:    rate = '0;
        endcase
        step    = rate[15:8];
        dc_inc  = cur_dc + 8'd1;
        fire    = (dc_inc >= rate[7:0]);
        sum     = {1'b0, cur_lvl} + {1'b0, step};
        nx_ph   = cur_ph;
        nx_lvl  = cur_lvl;
        nx_dc   = cur_dc;
        nx_free = 1'b0;
        if (cur_ph != PH_OFF) begin
            nx_dc = fire ? 8'd0 : dc_inc;
            if (fire) begin
                case (cur_ph)
                    PH_ATTACK: begin
                        nx_lvl = sum[8] ? 8'hFF : sum[7:0];
                        if (nx_lvl >= r_attack_target) nx_ph = PH_DECAY;
                    end
                    PH_DECAY: begin
                        nx_lvl = (cur_lvl > step) ? cur_lvl - step : 8'd0;
                        if (nx_lvl <= r_decay_target) nx_ph = PH_SUSTAIN;
                    end
                    default: begin
                        // sustain and release fade out the same way
                        if (cur_lvl <= step) begin
                            nx_ph   = PH_OFF;
                            nx_free = (cur_ph == PH_SUSTAIN);
                        end else begin
                            nx_lvl = cur_lvl - step;
                        end
                    end
                endcase
            end
        end
    end

    // Note-off phase change
    always_comb begin
        off_chg = (cur_ph == PH_ATTACK) || (cur_ph == PH_DECAY) || (cur_ph == PH_SUSTAIN);
        off_ph  = off_chg ? PH_RELEASE : cur_ph;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_target <= 8'd128;
            r_attack_rate   <= 16'h8000;
            r_decay_target  <= 8'd128;
            r_decay_rate    <= 16'h0100;
            r_sustain_rate  <= 16'h00FF;
            r_release_rate  <= 16'h8000;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ATTACK_TARGET: r_attack_target <= i_cfg_wdata[7:0];
                CFG_ATTACK_RATE:   r_attack_rate   <= i_cfg_wdata;
                CFG_DECAY_TARGET:  r_decay_target  <= i_cfg_wdata[7:0];
                CFG_DECAY_RATE:    r_decay_rate    <= i_cfg_wdata;
                CFG_SUSTAIN_RATE:  r_sustain_rate  <= i_cfg_wdata;
                CFG_RELEASE_RATE:  r_release_rate  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Beat capture and voice counter; a note-off points the counter at its voice
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_sel    <= i_in_data.voice_sel;
            r_sel_ok <= sel_in_range;
            if (i_in_data.mode == MODE_NOTE_OFF && sel_in_range) begin
                r_cnt <= VW'(i_in_data.voice_sel);
            end else begin
                r_cnt <= '0;
            end
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + VW'(1);
        end
    end

    // Voice state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
                r_phase[v] <= PH_OFF;
                r_delay[v] <= '0;
                r_level[v] <= '0;
            end
            r_busy <= '0;
        end else begin
            if (i_cmd.do_tick) begin
                r_phase[r_cnt] <= nx_ph;
                r_delay[r_cnt] <= nx_dc;
                r_level[r_cnt] <= nx_lvl;
                if (nx_free) r_busy[r_cnt] <= 1'b0;
            end
            if (i_cmd.do_alloc) begin
                r_phase[r_cnt] <= PH_ATTACK;
                r_delay[r_cnt] <= '0;
                r_level[r_cnt] <= '0;
                r_busy[r_cnt]  <= 1'b1;
            end
            if (i_cmd.do_off && r_sel_ok) begin
                r_phase[r_cnt] <= off_ph;
                if (off_chg) r_delay[r_cnt] <= '0;
                r_busy[r_cnt] <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.do_tick && o_stat.cnt_report) || i_cmd.do_alloc ||
                     i_cmd.do_nogrant || i_cmd.do_off) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_tick && o_stat.cnt_report) begin
            r_out.voice_index <= 3'(r_cnt);
            r_out.level       <= nx_lvl;
            r_out.phase_code  <= nx_ph;
            r_out.granted     <= 1'b0;
            r_out.last        <= report_last;
        end else if (i_cmd.do_alloc) begin
            r_out.voice_index <= 3'(r_cnt);
            r_out.level       <= '0;
            r_out.phase_code  <= PH_ATTACK;
            r_out.granted     <= 1'b1;
            r_out.last        <= 1'b1;
        end else if (i_cmd.do_nogrant) begin
            r_out.voice_index <= '0;
            r_out.level       <= '0;
            r_out.phase_code  <= PH_OFF;
            r_out.granted     <= 1'b0;
            r_out.last        <= 1'b1;
        end else if (i_cmd.do_off) begin
            r_out.voice_index <= r_sel;
            r_out.level       <= r_sel_ok ? cur_lvl : 8'd0;
            r_out.phase_code  <= r_sel_ok ? off_ph : PH_OFF;
            r_out.granted     <= 1'b0;
            r_out.last        <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/polyphonic_adsr_envelope.sv
// Top level of the polyphonic ADSR envelope generator with voice allocation.
// One beat in is a tick, a note-on or a note-off. Once the beat is taken,
// one voice of the register file is visited per cycle through its single
// read/write port while the output register can take a result. A tick
// steps all NUM_VOICES voices and returns one beat per voice for the
// first min(NUM_VOICES, 8); a note-on scans voices from 0 up to the first
// free one and a note-off goes straight to its voice, each returning a
// single beat. The input stalls while a beat is being worked on; a result
// waiting in the output register does not stop the next beat from being
// taken. All voice state is cleared at reset, with no clearing pass.
module polyphonic_adsr_envelope #(
    parameter int NUM_VOICES = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [pae_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pae_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pae_pkg::t_in_beat              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pae_pkg::t_out_beat             o_out_data
);
    import pae_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    pae_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_mode     (i_in_data.mode),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pae_datapath #(
        .NUM_VOICES (NUM_VOICES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
